### hw/rtl/aer_pkg.sv
// Shared types and constants of the audio elastic ring buffer.
`default_nettype none

package aer_pkg;

  // Fixed field widths of the stream items
  localparam int SAMPLE_W      = 32;
  localparam int SAMPLE_FIELDS = 4;
  localparam int FILL_W        = 14;
  localparam int CNT_W         = 32;
  localparam int IN_TDATA_W    = SAMPLE_FIELDS * SAMPLE_W;
  // samples, fill level and two counters, padded to whole bytes
  localparam int OUT_BITS      = SAMPLE_FIELDS * SAMPLE_W + FILL_W + 2 * CNT_W;
  localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

  // Configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;
  localparam int CAP_CFG_W  = 14;
  localparam int CHAN_CFG_W = 3;

  localparam logic [CFG_IDX_W-1:0]  REG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_CHANNELS = 1'd1;
  localparam logic [CAP_CFG_W-1:0]  CAP_RESET    = 14'd5760;
  localparam logic [CHAN_CFG_W-1:0] CHAN_RESET   = 3'd2;

  localparam int MIN_CAPACITY = 256;

  // Item kind carried in tuser
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Per-item status handed from the control to the result stage
  typedef struct packed {
    logic                     underrun;
    logic                     dropped;
    logic [FILL_W-1:0]        fill;
    logic [CNT_W-1:0]         underrun_total;
    logic [CNT_W-1:0]         dropped_total;
    logic [SAMPLE_FIELDS-1:0] ch_en;
    logic                     last;
  } aer_meta_t;

endpackage

`default_nettype wire

### hw/rtl/aer_store.sv
// Frame store: one frame per word, one access per cycle, registered read data.
`default_nettype none

module aer_store #(
  parameter int DEPTH  = 8192,
  parameter int WIDTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read port; read data holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/aer_ctrl.sv
// Ring control: config registers, indices, occupancy and saturating counters.
`default_nettype none

module aer_ctrl
  import aer_pkg::*;
#(
  parameter int MAX_FRAMES = 8192,
  parameter int STORE_CH   = 4,
  parameter int IDX_W      = $clog2(MAX_FRAMES),
  parameter int CAP_W      = $clog2(MAX_FRAMES + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                      accept,
  input  wire logic                      kind,
  input  wire logic                      last,
  input  wire logic [IN_TDATA_W-1:0]     samples,
  output logic                           mem_we,
  output logic                           mem_re,
  output logic      [IDX_W-1:0]          mem_addr,
  output logic      [STORE_CH*SAMPLE_W-1:0] mem_wdata,
  output aer_meta_t                      meta_nxt
);

  localparam int CMP_W = (CAP_W > CAP_CFG_W) ? CAP_W : CAP_CFG_W;

  logic [CAP_CFG_W-1:0]  cap_cfg_r;
  logic [CHAN_CFG_W-1:0] chan_cfg_r;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]      wr_idx_r, wr_idx_nxt;
  logic [CAP_W-1:0]      occ_r, occ_nxt;
  logic [CNT_W-1:0]      ut_r, ut_nxt;
  logic [CNT_W-1:0]      dt_r, dt_nxt;

  logic [CMP_W-1:0]      cap_ext;
  logic [CAP_W-1:0]      cap;
  logic [CHAN_CFG_W-1:0] nch;
  logic [CAP_W-1:0]      rd_inc, wr_inc;
  logic [IDX_W-1:0]      rd_adv, wr_adv;
  logic                  under, drop;

  // Effective capacity, clamped to MIN_CAPACITY..MAX_FRAMES
  always_comb begin
    cap_ext = CMP_W'(cap_cfg_r);
    if (cap_ext < CMP_W'(MIN_CAPACITY)) begin
      cap_ext = CMP_W'(MIN_CAPACITY);
    end
    if (cap_ext > CMP_W'(MAX_FRAMES)) begin
      cap_ext = CMP_W'(MAX_FRAMES);
    end
    cap = CAP_W'(cap_ext);
  end

  // Effective channel count, clamped to 1..STORE_CH
  always_comb begin
    nch = chan_cfg_r;
    if (nch == '0) begin
      nch = CHAN_CFG_W'(1);
    end
    if (nch > CHAN_CFG_W'(STORE_CH)) begin
      nch = CHAN_CFG_W'(STORE_CH);
    end
  end

  // Index advance with wrap at the capacity
  assign rd_inc = CAP_W'(rd_idx_r) + CAP_W'(1);
  assign wr_inc = CAP_W'(wr_idx_r) + CAP_W'(1);
  assign rd_adv = (rd_inc >= cap) ? '0 : IDX_W'(rd_inc);
  assign wr_adv = (wr_inc >= cap) ? '0 : IDX_W'(wr_inc);

  // Next state for one item
  always_comb begin
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    occ_nxt    = occ_r;
    ut_nxt     = ut_r;
    dt_nxt     = dt_r;
    under      = 1'b0;
    drop       = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = wr_idx_r;
    if (accept) begin
      if (kind == KIND_WRITE) begin
        mem_we = 1'b1;
        if (occ_r >= cap) begin
          // full: the oldest frame goes
          drop       = 1'b1;
          rd_idx_nxt = rd_adv;
          dt_nxt     = (dt_r == '1) ? dt_r : dt_r + CNT_W'(1);
        end else begin
          occ_nxt = occ_r + CAP_W'(1);
        end
        wr_idx_nxt = wr_adv;
      end else begin
        mem_addr = rd_idx_r;
        if (occ_r != '0) begin
          mem_re     = 1'b1;
          rd_idx_nxt = rd_adv;
          occ_nxt    = occ_r - CAP_W'(1);
        end else begin
          // empty: silence
          under  = 1'b1;
          ut_nxt = (ut_r == '1) ? ut_r : ut_r + CNT_W'(1);
        end
      end
    end
  end

  // Write data: unused channel slots are stored as zero
  always_comb begin
    for (int c = 0; c < STORE_CH; c++) begin
      mem_wdata[c*SAMPLE_W +: SAMPLE_W] =
        (CHAN_CFG_W'(c) < nch) ? samples[c*SAMPLE_W +: SAMPLE_W] : '0;
    end
  end

  // Status of this item for the result stage
  always_comb begin
    meta_nxt.underrun       = under;
    meta_nxt.dropped        = drop;
    meta_nxt.fill           = FILL_W'(occ_nxt);
    meta_nxt.underrun_total = ut_nxt;
    meta_nxt.dropped_total  = dt_nxt;
    meta_nxt.last           = last;
    for (int c = 0; c < SAMPLE_FIELDS; c++) begin
      meta_nxt.ch_en[c] = mem_re && (CHAN_CFG_W'(c) < nch);
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_cfg_r  <= CAP_RESET;
      chan_cfg_r <= CHAN_RESET;
      rd_idx_r   <= '0;
      wr_idx_r   <= '0;
      occ_r      <= '0;
      ut_r       <= '0;
      dt_r       <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_CAPACITY: cap_cfg_r  <= CAP_CFG_W'(cfg_data);
          REG_CHANNELS: chan_cfg_r <= cfg_data[CHAN_CFG_W-1:0];
          default: ;
        endcase
      end
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
      occ_r    <= occ_nxt;
      ut_r     <= ut_nxt;
      dt_r     <= dt_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/aer_out.sv
// Result register: holds one item's status, masks the read data, drives the output.
`default_nettype none

module aer_out
  import aer_pkg::*;
#(
  parameter int STORE_CH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire aer_meta_t                    meta_nxt,
  input  wire logic [STORE_CH*SAMPLE_W-1:0] rdata,
  input  wire logic                         out_tready,
  output logic                              in_tready,
  output logic                              out_tvalid,
  output logic      [OUT_TDATA_W-1:0]       out_tdata,
  output logic      [1:0]                   out_tuser,
  output logic                              out_tlast
);

  logic      valid_r;
  aer_meta_t meta_r;
  logic [SAMPLE_FIELDS*SAMPLE_W-1:0] smp;

  // A new item may enter whenever the held result leaves or none is held
  assign in_tready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meta_r <= meta_nxt;
    end
  end

  // Sample words: zero for writes, underruns and channels not in use
  for (genvar c = 0; c < SAMPLE_FIELDS; c++) begin : g_smp
    if (c < STORE_CH) begin : g_used
      assign smp[c*SAMPLE_W +: SAMPLE_W] =
        meta_r.ch_en[c] ? rdata[c*SAMPLE_W +: SAMPLE_W] : '0;
    end else begin : g_none
      assign smp[c*SAMPLE_W +: SAMPLE_W] = '0;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = OUT_TDATA_W'({meta_r.dropped_total, meta_r.underrun_total,
                                    meta_r.fill, smp});
  assign out_tuser  = {meta_r.dropped, meta_r.underrun};
  assign out_tlast  = meta_r.last;

endmodule

`default_nettype wire

### hw/rtl/audio_elastic_ring_buffer.sv
// Top level of the audio elastic ring buffer.
//
// Each item on the input stream either writes one frame into the ring
// (in_tuser = 0) or reads one frame out (in_tuser = 1); in_tlast marks the
// end of a transfer and comes back on out_tlast. Every item gives exactly one
// result item: the frame read (zero on a write or an underrun), the underrun
// and drop flags in out_tuser, the fill level and both saturating counters.
// A write into a full ring drops the oldest frame; a read from an empty ring
// returns silence.
// Capacity and channel count are set on the cfg_ port (always ready).
// The result of an item accepted at a clock edge is registered and shown
// after that edge. Throughput is one item per cycle, set by the single
// access port of the frame store, while the result side does not stall. The
// result register holds while out_tready is low, and a new item is still
// taken in the cycle the held result leaves. Reset clears indices, occupancy
// and counters, loads the register defaults and empties the result register;
// frame contents are not cleared.
`default_nettype none

module audio_elastic_ring_buffer
  import aer_pkg::*;
#(
  parameter int MAX_FRAMES   = 8192,
  parameter int MAX_CHANNELS = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,  // sample_0, sample_1, sample_2, sample_3
  input  wire logic                   in_tuser,  // kind
  input  wire logic                   in_tlast,  // burst_end
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // out_sample_0..3, fill_level, underrun_total, dropped_total, zero pad
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic      [1:0]             out_tuser, // underrun, dropped
  output logic                        out_tlast, // burst_end_out
  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int STORE_CH = (MAX_CHANNELS < SAMPLE_FIELDS) ? MAX_CHANNELS : SAMPLE_FIELDS;
  localparam int IDX_W    = $clog2(MAX_FRAMES);
  localparam int STORE_W  = STORE_CH * SAMPLE_W;

  logic               accept;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_addr;
  logic [STORE_W-1:0] mem_wdata, mem_rdata;
  aer_meta_t          meta_nxt;

  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;

  aer_ctrl #(
    .MAX_FRAMES (MAX_FRAMES),
    .STORE_CH   (STORE_CH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .kind      (in_tuser),
    .last      (in_tlast),
    .samples   (in_tdata),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .meta_nxt  (meta_nxt)
  );

  aer_store #(
    .DEPTH (MAX_FRAMES),
    .WIDTH (STORE_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  aer_out #(
    .STORE_CH (STORE_CH)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .meta_nxt   (meta_nxt),
    .rdata      (mem_rdata),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

### hw/rtl/aer_checker.sv
// Port-level checks on the audio elastic ring buffer, bound to the top level.
`default_nettype none

module aer_checker
  import aer_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [1:0]             out_tuser
);

  // A held result stays offered until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // An item is one write or one read, never both outcomes
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("underrun and drop on one item");

  // An underrun gives a silent frame
  a_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[SAMPLE_FIELDS*SAMPLE_W-1:0] == '0)
    else $error("underrun frame not silent");

  // An accepted item yields a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("no result after accepted item");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind audio_elastic_ring_buffer aer_checker u_aer_checker (.*);

`default_nettype wire

### dv/audio_elastic_ring_buffer_tb.sv
// Self-checking testbench of the audio elastic ring buffer.
`timescale 1ns / 1ps

module audio_elastic_ring_buffer_tb;
  import aer_pkg::*;

  localparam int RING_DEPTH = 8192;
  localparam int NUM_PHASES = 8;
  localparam int HOLD_CYCLES = 80;
  localparam int FILL_LO = SAMPLE_FIELDS * SAMPLE_W;
  localparam int UNDER_LO = FILL_LO + FILL_W;
  localparam int DROP_LO = UNDER_LO + CNT_W;

  typedef logic [SAMPLE_FIELDS-1:0][SAMPLE_W-1:0] frame_t;

  typedef struct packed {
    frame_t            smp;
    logic              underrun;
    logic              dropped;
    logic [FILL_W-1:0] fill;
    logic [CNT_W-1:0]  under_total;
    logic [CNT_W-1:0]  drop_total;
    logic              last;
  } ring_result_t;

  // Ring predictor and result checker
  class frame_ring_checker;
    logic [SAMPLE_W-1:0] frames [RING_DEPTH][SAMPLE_FIELDS];
    bit                  written [RING_DEPTH];
    int unsigned         rd_idx = 0;
    int unsigned         wr_idx = 0;
    int unsigned         occ = 0;
    logic [CNT_W-1:0]    under_cnt = '0;
    logic [CNT_W-1:0]    drop_cnt = '0;
    logic [CAP_CFG_W-1:0]  cap_reg = CAP_RESET;
    logic [CHAN_CFG_W-1:0] chan_reg = CHAN_RESET;
    ring_result_t        due_results [$];
    int                  errors = 0;
    int                  n_writes = 0;
    int                  n_reads = 0;
    int                  n_under = 0;
    int                  n_drops = 0;
    int                  n_settings = 1;

    function int unsigned eff_cap();
      int unsigned c;
      c = cap_reg;
      if (c < MIN_CAPACITY) c = MIN_CAPACITY;
      if (c > RING_DEPTH) c = RING_DEPTH;
      return c;
    endfunction

    function int unsigned eff_chan();
      int unsigned n;
      n = chan_reg;
      if (n < 1) n = 1;
      if (n > SAMPLE_FIELDS) n = SAMPLE_FIELDS;
      return n;
    endfunction

    function int unsigned next_idx(int unsigned idx, int unsigned cap);
      return (idx + 1 >= cap) ? 0 : idx + 1;
    endfunction

    function logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_CAPACITY) cap_reg = val[CAP_CFG_W-1:0];
      else if (idx == REG_CHANNELS) chan_reg = val[CHAN_CFG_W-1:0];
      n_settings++;
    endfunction

    // a read would land on a slot that has never been filled
    function bit head_unwritten();
      return occ > 0 && !written[rd_idx % RING_DEPTH];
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void accept_item(logic kind, frame_t smp, logic last);
      ring_result_t r;
      int unsigned  cap;
      int unsigned  nch;
      int unsigned  slot;
      cap = eff_cap();
      nch = eff_chan();
      r = '0;
      r.last = last;
      if (kind == KIND_WRITE) begin
        n_writes++;
        // full ring: oldest frame goes first
        if (occ >= cap) begin
          rd_idx = next_idx(rd_idx, cap);
          drop_cnt = sat_inc(drop_cnt);
          r.dropped = 1'b1;
          n_drops++;
        end else begin
          occ++;
        end
        slot = wr_idx % RING_DEPTH;
        for (int c = 0; c < SAMPLE_FIELDS; c++)
          frames[slot][c] = (c < nch) ? smp[c] : '0;
        written[slot] = 1'b1;
        wr_idx = next_idx(wr_idx, cap);
      end else begin
        n_reads++;
        if (occ > 0) begin
          slot = rd_idx % RING_DEPTH;
          for (int c = 0; c < SAMPLE_FIELDS; c++)
            if (c < nch) r.smp[c] = frames[slot][c];
          rd_idx = next_idx(rd_idx, cap);
          occ--;
        end else begin
          // empty ring gives silence
          under_cnt = sat_inc(under_cnt);
          r.underrun = 1'b1;
          n_under++;
        end
      end
      r.fill = FILL_W'(occ);
      r.under_total = under_cnt;
      r.drop_total = drop_cnt;
      due_results.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] td, logic [1:0] tu, logic tl);
      ring_result_t e;
      if (due_results.size() == 0) begin
        $error("result item arrived with nothing outstanding");
        errors++;
        return;
      end
      e = due_results.pop_front();
      for (int c = 0; c < SAMPLE_FIELDS; c++)
        compare($sformatf("out_sample_%0d", c), e.smp[c], td[c*SAMPLE_W +: SAMPLE_W]);
      compare("underrun", 32'(e.underrun), 32'(tu[0]));
      compare("dropped", 32'(e.dropped), 32'(tu[1]));
      compare("fill_level", 32'(e.fill), 32'(td[FILL_LO +: FILL_W]));
      compare("underrun_total", e.under_total, td[UNDER_LO +: CNT_W]);
      compare("dropped_total", e.drop_total, td[DROP_LO +: CNT_W]);
      compare("burst_end_out", 32'(e.last), 32'(tl));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;  // sample_0, sample_1, sample_2, sample_3
  logic                   in_tuser = KIND_WRITE;  // kind
  logic                   in_tlast = 1'b0;  // burst_end
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // samples 0..3, fill_level, underrun_total, dropped_total
  logic [1:0]             out_tuser;  // underrun, dropped
  logic                   out_tlast;  // burst_end_out
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_CAPACITY;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  frame_ring_checker ring = new();
  bit steady_flow = 1'b0;
  bit hold_req = 1'b0;

  // Per-phase settings: capacity, channels, write share in percent, item count
  int unsigned cap_tbl [NUM_PHASES] = '{256, 0, 260, 16383, 8192, 300, 256, 1000};
  int unsigned chan_tbl [NUM_PHASES] = '{4, 8, 7, 5, 1, 3, 6, 2};
  int unsigned wpct_tbl [NUM_PHASES] = '{98, 90, 60, 20, 50, 95, 10, 50};
  int unsigned len_tbl [NUM_PHASES] = '{250, 170, 170, 170, 120, 170, 170, 130};

  audio_elastic_ring_buffer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Handshake monitor: results first, so an item never meets its own result
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) ring.check_result(out_tdata, out_tuser, out_tlast);
      if (in_tvalid && in_tready) ring.accept_item(in_tuser, in_tdata, in_tlast);
    end
  end

  // Result side: random back-pressure, one long hold-off on request
  always begin
    @(negedge clk);
    if (hold_req) begin
      out_tready <= 1'b0;
      repeat (HOLD_CYCLES - 1) @(negedge clk);
      hold_req = 1'b0;
    end else begin
      out_tready <= steady_flow || ($urandom_range(99) >= 20);
    end
  end

  // Offer one item from a falling edge on, with random idle cycles first
  task automatic drive_item(logic kind, frame_t smp, logic last);
    while (!steady_flow && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= smp;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_item(logic kind, frame_t smp, logic last);
    @(negedge clk);
    drive_item(kind, smp, last);
  endtask

  task automatic send_random(int unsigned write_pct);
    frame_t smp;
    logic   kind;
    for (int c = 0; c < SAMPLE_FIELDS; c++) begin
      case ($urandom_range(15))
        0: smp[c] = '0;
        1: smp[c] = '1;
        default: smp[c] = $urandom;
      endcase
    end
    // by the falling edge the previous item is booked, so the ring state is current
    @(negedge clk);
    kind = ($urandom_range(99) < write_pct) ? KIND_WRITE : KIND_READ;
    // never let a read reach a slot that was never filled
    if (kind == KIND_READ && ring.head_unwritten()) kind = KIND_WRITE;
    drive_item(kind, smp, $urandom_range(3) == 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    ring.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (ring.pending() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty read, extreme words, burst mark both ways, read past empty
    send_item(KIND_READ, '0, 1'b1);
    send_item(KIND_WRITE, '1, 1'b0);
    send_item(KIND_WRITE, '0, 1'b1);
    send_item(KIND_WRITE, {32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h5A5A_5A5A, 32'hA5A5_A5A5}, 1'b0);
    send_item(KIND_READ, '1, 1'b0);
    send_item(KIND_READ, '0, 1'b1);
    send_item(KIND_READ, '0, 1'b0);
    send_item(KIND_READ, '1, 1'b1);

    // random phases; capacity and channels change with frames still held
    for (int p = 0; p < NUM_PHASES; p++) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      wait_drained();
      write_reg(REG_CAPACITY, CFG_DATA_W'(cap_tbl[p]));
      write_reg(REG_CHANNELS, CFG_DATA_W'(chan_tbl[p]));
      steady_flow = (p == 1);
      for (int i = 0; i < len_tbl[p]; i++) begin
        if (p == 1 && i == 20) hold_req = 1'b1;
        send_random(wpct_tbl[p]);
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
    steady_flow = 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);

    if (ring.pending() != 0) begin
      $error("%0d expected result items never arrived", ring.pending());
      ring.errors++;
    end
    $display("Covered %0d items: %0d frame writes, %0d frame reads, %0d register settings.",
             ring.n_writes + ring.n_reads, ring.n_writes, ring.n_reads, ring.n_settings);
    $display("Saw %0d silent underrun frames and %0d oldest-frame drops.",
             ring.n_under, ring.n_drops);
    if (ring.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
